[sv/sq_pkg.sv]
// Shared types and codes for the shift queue with index read and sort.
// No dependencies; imported by sq_cell and the top level.
package sq_pkg;

	localparam int VAL_W = 31;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_SORT   = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_NOTFULL  = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	localparam logic [1:0] CM_HOLD  = 2'd0;
	localparam logic [1:0] CM_LOAD  = 2'd1;
	localparam logic [1:0] CM_SHIFT = 2'd2;
	localparam logic [1:0] CM_SORT  = 2'd3;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [VAL_W-1:0] value;
		logic [7:0]       index;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [VAL_W-1:0] read_value;
		logic             is_empty;
		logic             is_full;
	} rsp_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [VAL_W-1:0] ins_val;
	} cell_cmd_t;

endpackage

[sv/shift_queue_with_index_read_and_sort.sv]
// Top level: row of sq_cell slots, fill count, sequencer and response register.
// Depends on sq_pkg and sq_cell.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (req_t: opcode, value, index)
//   result  | rsp_valid | rsp_stall | rsp (rsp_t: status, read_value, flags)
//
// Insert, remove, and any beat answered without touching the row: no sequencer pass.
// Read within depth: the row rotates once past slot 0.
// Sort of a full queue: DEPTH odd-even compare-swap passes over the row.
// Reset clears every slot and the fill count; no clearing pass.
// A result waits in the output register; a new beat is taken while it drains.
module shift_queue_with_index_read_and_sort #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sq_pkg::req_t  req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sq_pkg::rsp_t  rsp
);
	import sq_pkg::*;

	localparam int CW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [FW-1:0] FULL_CNT = FW'(DEPTH);

	logic [VAL_W-1:0] slot_val [DEPTH];
	logic [VAL_W-1:0] wrap_val;
	cell_cmd_t        cmd;

	logic [FW-1:0]    fill_q, fill_d;
	logic             busy_q;
	logic [1:0]       op_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic [VAL_W-1:0] rd_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             is_full, is_empty;
	logic             idx_out;
	logic             last_pass;
	logic             hit;
	logic [VAL_W-1:0] rd_now;
	logic             imm_done;
	rsp_t             imm_rsp;
	logic             start;

	assign req_stall = busy_q | (rsp_valid_q & rsp_stall);
	assign accept    = req_valid & ~req_stall;
	assign is_full   = (fill_q == FULL_CNT);
	assign is_empty  = (fill_q == '0);
	assign idx_out   = ({1'b0, req.index} >= 9'(DEPTH));
	assign last_pass = (cnt_q == CW'(DEPTH - 1));
	assign hit       = (cnt_q == idx_q);
	assign rd_now    = hit ? slot_val[0] : rd_q;
	assign wrap_val  = (busy_q && op_q == OP_READ) ? slot_val[0] : '0;

	always_comb begin
		cmd.mode    = CM_HOLD;
		cmd.ins_val = req.value;
		fill_d      = fill_q;
		imm_done    = 1'b0;
		start       = 1'b0;
		imm_rsp     = '0;
		if (busy_q) begin
			cmd.mode = (op_q == OP_READ) ? CM_SHIFT : CM_SORT;
		end else if (accept) begin
			case (req.opcode)
				OP_INSERT: begin
					imm_done = 1'b1;
					if (is_full) begin
						imm_rsp.status = ST_FULL;
					end else if (req.value != '0) begin
						cmd.mode = CM_LOAD;
						fill_d   = fill_q + 1'b1;
					end
				end
				OP_REMOVE: begin
					imm_done = 1'b1;
					if (is_empty) begin
						imm_rsp.status = ST_EMPTY;
					end else begin
						cmd.mode = CM_SHIFT;
						fill_d   = fill_q - 1'b1;
					end
				end
				OP_READ: begin
					if (idx_out) begin
						imm_done       = 1'b1;
						imm_rsp.status = ST_NOTFOUND;
					end else begin
						start = 1'b1;
					end
				end
				default: begin
					if (!is_full) begin
						imm_done       = 1'b1;
						imm_rsp.status = ST_NOTFULL;
					end else begin
						start = 1'b1;
					end
				end
			endcase
		end
		imm_rsp.is_empty = (fill_d == '0);
		imm_rsp.is_full  = (fill_d == FULL_CNT);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic PAR = 1'(i % 2);
		logic             sel, pair_r, pair_l;
		logic [VAL_W-1:0] left_v, right_v;

		assign sel = (fill_q == FW'(i));
		if (i == 0) begin : g_head
			assign pair_l = 1'b0;
			assign left_v = '0;
		end else begin : g_mid_l
			assign pair_l = (cnt_q[0] != PAR);
			assign left_v = slot_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign pair_r  = 1'b0;
			assign right_v = wrap_val;
		end else begin : g_mid_r
			assign pair_r  = (cnt_q[0] == PAR);
			assign right_v = slot_val[i+1];
		end

		sq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.sel       (sel),
			.pair_r    (pair_r),
			.pair_l    (pair_l),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (slot_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (imm_done || (busy_q && last_pass)) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_pass) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= req.opcode;
			idx_q <= req.index[CW-1:0];
			rd_q  <= '0;
		end else if (busy_q && hit) begin
			rd_q <= slot_val[0];
		end
		if (imm_done) begin
			rsp_q <= imm_rsp;
		end else if (busy_q && last_pass) begin
			rsp_q.is_empty <= is_empty;
			rsp_q.is_full  <= is_full;
			if (op_q == OP_READ) begin
				rsp_q.status     <= (rd_now == '0) ? ST_NOTFOUND : ST_OK;
				rsp_q.read_value <= rd_now;
			end else begin
				rsp_q.status     <= ST_OK;
				rsp_q.read_value <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/sq_cell.sv]
// One slot of the queue: loads, shifts towards the head, or compare-swaps
// with a neighbour. Depends on sq_pkg.
module sq_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sq_pkg::cell_cmd_t       cmd,
	input  logic                    sel,
	input  logic                    pair_r,
	input  logic                    pair_l,
	input  logic [sq_pkg::VAL_W-1:0] left_val,
	input  logic [sq_pkg::VAL_W-1:0] right_val,
	output logic [sq_pkg::VAL_W-1:0] val
);
	import sq_pkg::*;

	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] val_d;

	always_comb begin
		val_d = val_q;
		case (cmd.mode)
			CM_LOAD: begin
				if (sel) val_d = cmd.ins_val;
			end
			CM_SHIFT: val_d = right_val;
			CM_SORT: begin
				if (pair_r && (val_q > right_val)) val_d = right_val;
				else if (pair_l && (left_val > val_q)) val_d = left_val;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) val_q <= '0;
		else val_q <= val_d;
	end

	assign val = val_q;

endmodule
